// ===== sv/cbm_pkg.sv =====
// Shared types, codes and helper functions of the cartridge bank mapper.
// Used by cbm_rtc, cbm_map and the top level cartridge_bank_mapper_with_rtc.
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

  // Request codes.
  localparam logic [2:0] REQ_REG_WRITE = 3'd0;
  localparam logic [2:0] REQ_ROM_READ  = 3'd1;
  localparam logic [2:0] REQ_RAM_READ  = 3'd2;
  localparam logic [2:0] REQ_RAM_WRITE = 3'd3;
  localparam logic [2:0] REQ_TICK      = 3'd4;

  // Result access kinds.
  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_ROM_READ  = 3'd1;
  localparam logic [2:0] KIND_RAM_READ  = 3'd2;
  localparam logic [2:0] KIND_RAM_WRITE = 3'd3;
  localparam logic [2:0] KIND_DATA      = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROM_ADDR_BITS = 2'd0;
  localparam logic [1:0] CFG_RAM_ADDR_BITS = 2'd1;
  localparam logic [1:0] CFG_HAS_RTC       = 2'd2;

  // Clock register selects, the low bits of the RAM bank register.
  localparam logic [2:0] RTC_SECONDS = 3'd0;
  localparam logic [2:0] RTC_MINUTES = 3'd1;
  localparam logic [2:0] RTC_HOURS   = 3'd2;
  localparam logic [2:0] RTC_DAYS    = 3'd3;
  localparam logic [2:0] RTC_FLAGS   = 3'd4;

  localparam int MaxRomAddrWidth = 21;
  localparam int MemAddrWidth    = 21;

  localparam logic [4:0] ROM_ADDR_BITS_RESET = 5'd15;
  localparam logic [3:0] RAM_ADDR_BITS_RESET = 4'd13;

  localparam logic [7:0] RAM_ENABLE_CODE = 8'h0A;
  localparam logic [7:0] FLAGS_KEEP      = 8'hC0;
  localparam logic [7:0] FLAGS_LATCH     = 8'hC1;

  // Requests from the mapper to the clock unit, at most one per item.
  typedef struct packed {
    logic       tick;
    logic       latch;
    logic       wr;
    logic [2:0] wr_sel;
    logic [7:0] wr_data;
  } rtc_ctrl_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic [MemAddrWidth-1:0] mem_addr;
    logic [7:0]              write_data;
    logic [7:0]              read_data;
  } result_t;

  // Remainder by 60 of a byte, by restoring subtraction of 240, 120 and 60.
  function automatic logic [5:0] mod60(input logic [7:0] x);
    logic [7:0] r;
    r = x;
    if (r >= 8'd240) r = r - 8'd240;
    if (r >= 8'd120) r = r - 8'd120;
    if (r >= 8'd60) r = r - 8'd60;
    return r[5:0];
  endfunction

  // Remainder by 24 of a byte, by restoring subtraction of 192, 96, 48 and 24.
  function automatic logic [4:0] mod24(input logic [7:0] x);
    logic [7:0] r;
    r = x;
    if (r >= 8'd192) r = r - 8'd192;
    if (r >= 8'd96) r = r - 8'd96;
    if (r >= 8'd48) r = r - 8'd48;
    if (r >= 8'd24) r = r - 8'd24;
    return r[4:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/cbm_rtc.sv =====
// Real-time clock counters and their latched copy.
// Depends on cbm_pkg for the control struct and the remainder functions.
`timescale 1ns / 1ps
`default_nettype none

module cbm_rtc
  import cbm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire rtc_ctrl_t  ctrl,
  input  wire logic [2:0] rd_sel,
  output logic      [7:0] rd_byte
);

  logic [7:0] seconds;
  logic [7:0] minutes;
  logic [7:0] hours;
  logic [7:0] day_low;
  logic [7:0] flags;
  logic [7:0] latched [5];

  logic       halted;
  logic [5:0] sec_mod;
  logic [5:0] min_mod;
  logic [4:0] hour_mod;
  logic [5:0] sec_inc;
  logic [5:0] min_inc;
  logic [4:0] hour_inc;
  logic       sec_carry;
  logic       min_carry;
  logic       hour_carry;
  logic [9:0] days_inc;

  logic [7:0] seconds_next;
  logic [7:0] minutes_next;
  logic [7:0] hours_next;
  logic [7:0] day_low_next;
  logic [7:0] flags_next;

  assign halted   = flags[6];
  assign sec_mod  = mod60(seconds);
  assign min_mod  = mod60(minutes);
  assign hour_mod = mod24(hours);

  // One-second carry chain over the reduced counters.
  always_comb begin
    sec_inc    = sec_mod + 6'd1;
    sec_carry  = (sec_inc == 6'd60);
    min_inc    = min_mod + {5'd0, sec_carry};
    min_carry  = (min_inc == 6'd60);
    hour_inc   = hour_mod + {4'd0, min_carry};
    hour_carry = (hour_inc == 5'd24);
    days_inc   = {1'b0, flags[0], day_low} + {9'd0, hour_carry};
  end

  always_comb begin
    seconds_next = seconds;
    minutes_next = minutes;
    hours_next   = hours;
    day_low_next = day_low;
    flags_next   = flags;
    if (ctrl.tick && !halted) begin
      seconds_next = sec_carry ? 8'd0 : {2'd0, sec_inc};
      minutes_next = min_carry ? 8'd0 : {2'd0, min_inc};
      hours_next   = hour_carry ? 8'd0 : {3'd0, hour_inc};
      day_low_next = days_inc[7:0];
      flags_next   = (flags & FLAGS_KEEP) | {days_inc[9], 6'd0, days_inc[8]};
    end else if (ctrl.latch && !halted) begin
      // Normalizing keeps the day count and clears the unused flag bits.
      seconds_next = {2'd0, sec_mod};
      minutes_next = {2'd0, min_mod};
      hours_next   = {3'd0, hour_mod};
      flags_next   = flags & FLAGS_LATCH;
    end else if (ctrl.wr) begin
      case (ctrl.wr_sel)
        RTC_SECONDS: seconds_next = ctrl.wr_data;
        RTC_MINUTES: minutes_next = ctrl.wr_data;
        RTC_HOURS:   hours_next   = ctrl.wr_data;
        RTC_DAYS:    day_low_next = ctrl.wr_data;
        RTC_FLAGS:   flags_next   = ctrl.wr_data;
        default:     flags_next   = flags;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds <= '0;
      minutes <= '0;
      hours   <= '0;
      day_low <= '0;
      flags   <= '0;
      for (int i = 0; i < 5; i++) latched[i] <= '0;
    end else begin
      seconds <= seconds_next;
      minutes <= minutes_next;
      hours   <= hours_next;
      day_low <= day_low_next;
      flags   <= flags_next;
      if (ctrl.latch) begin
        latched[0] <= seconds_next & 8'h3F;
        latched[1] <= minutes_next & 8'h3F;
        latched[2] <= hours_next & 8'h1F;
        latched[3] <= day_low_next;
        latched[4] <= flags_next & FLAGS_LATCH;
      end
    end
  end

  always_comb begin
    case (rd_sel)
      RTC_SECONDS: rd_byte = latched[0];
      RTC_MINUTES: rd_byte = latched[1];
      RTC_HOURS:   rd_byte = latched[2];
      RTC_DAYS:    rd_byte = latched[3];
      RTC_FLAGS:   rd_byte = latched[4];
      default:     rd_byte = 8'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/cbm_map.sv =====
// Mapper registers and request decode: bank registers, address mapping,
// and the control sent to the clock unit. Depends on cbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbm_map
  import cbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] addr,
  input  wire logic [7:0]  data,
  input  wire logic [4:0]  rom_addr_bits,
  input  wire logic [3:0]  ram_addr_bits,
  input  wire logic        has_rtc,
  input  wire logic [7:0]  rtc_byte,
  output logic      [2:0]  rtc_sel,
  output rtc_ctrl_t        rtc_ctrl,
  output result_t          result
);

  logic [7:0] ram_enable;
  logic [7:0] rom_bank;
  logic [7:0] ram_bank;
  logic [7:0] latch_ctrl;

  logic        ram_on;
  logic        clock_sel;
  logic [6:0]  bank;
  logic [4:0]  rom_bits;
  logic [20:0] rom_mask;
  logic [20:0] rom_addr;
  logic [14:0] ram_mask;
  logic [14:0] ram_addr;
  logic        latch_wr;

  assign ram_on    = (ram_enable[3:0] == RAM_ENABLE_CODE[3:0]);
  assign clock_sel = ram_bank inside {[8'h08:8'h0C]};
  assign rtc_sel   = ram_bank[2:0];
  assign latch_wr  = (req_type == REQ_REG_WRITE) && (addr >= 16'h6000) && has_rtc;

  always_comb begin
    bank     = (rom_bank[6:0] == 7'd0) ? 7'd1 : rom_bank[6:0];
    rom_bits = (rom_addr_bits > 5'(MaxRomAddrWidth)) ? 5'(MaxRomAddrWidth) : rom_addr_bits;
    for (int i = 0; i < 21; i++) rom_mask[i] = (5'(i) < rom_bits);
    for (int i = 0; i < 15; i++) ram_mask[i] = (4'(i) < ram_addr_bits);
    rom_addr = {bank, addr[13:0]} & rom_mask;
    ram_addr = {ram_bank[1:0], addr[12:0]} & ram_mask;
  end

  always_comb begin
    rtc_ctrl = '0;
    result   = '0;
    rtc_ctrl.wr_sel  = ram_bank[2:0];
    rtc_ctrl.wr_data = data;
    case (req_type)
      REQ_REG_WRITE: begin
        rtc_ctrl.latch = fire && latch_wr && (latch_ctrl == 8'h00) && (data == 8'h01);
      end
      REQ_ROM_READ: begin
        result.kind     = KIND_ROM_READ;
        result.mem_addr = rom_addr;
      end
      REQ_RAM_READ: begin
        result.kind = KIND_DATA;
        if (!ram_on) begin
          result.read_data = 8'hFF;
        end else if (clock_sel) begin
          result.read_data = rtc_byte;
        end else begin
          result.kind     = KIND_RAM_READ;
          result.mem_addr = {6'd0, ram_addr};
        end
      end
      REQ_RAM_WRITE: begin
        if (ram_on) begin
          if (clock_sel) begin
            rtc_ctrl.wr = fire;
          end else begin
            result.kind       = KIND_RAM_WRITE;
            result.mem_addr   = {6'd0, ram_addr};
            result.write_data = data;
          end
        end
      end
      REQ_TICK: begin
        rtc_ctrl.tick = fire;
      end
      default: begin
        result.kind = KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enable <= '0;
      rom_bank   <= '0;
      ram_bank   <= '0;
      latch_ctrl <= '0;
    end else if (fire && (req_type == REQ_REG_WRITE)) begin
      if (addr < 16'h2000) begin
        ram_enable <= data;
      end else if (addr < 16'h4000) begin
        rom_bank <= data;
      end else if (addr < 16'h6000) begin
        ram_bank <= data;
      end else if (latch_wr) begin
        latch_ctrl <= data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/cartridge_bank_mapper_with_rtc.sv =====
// Top level of the cartridge bank mapper with real-time clock: item and
// result channels, configuration registers and the two pipeline registers.
// Depends on cbm_pkg, cbm_map and cbm_rtc.
//
// Usage: each request item (req_type, addr, data) is taken on item_valid and
// item_ready; exactly one result item (access_kind, mem_addr, write_data,
// read_data) comes back on result_valid and result_ready, in order.
// An accepted item sits in the input register, where the decode, bank and
// clock updates are done, and its result is then held in the result
// register: result_valid rises when the item leaves the input register, and
// the result handshake comes at an edge where result_ready is high.
// Throughput is one item per cycle while result_ready is held high; the input
// register and the result register each hold one item, so one new item is
// taken while a result waits. When the receiver stalls, both registers fill
// and item_ready drops until result_ready returns.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and must be written only while no item is in flight.
// Reset (rst, synchronous) empties both registers, clears the mapper and
// clock registers and loads the configuration reset values.
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_mapper_with_rtc
  import cbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] addr,
  input  wire logic [7:0]  data,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic      [2:0]  access_kind,
  output logic      [20:0] mem_addr,
  output logic      [7:0]  write_data,
  output logic      [7:0]  read_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);

  logic [4:0] rom_addr_bits;
  logic [3:0] ram_addr_bits;
  logic       has_rtc;

  logic        stage_valid;
  logic [2:0]  stage_req;
  logic [15:0] stage_addr;
  logic [7:0]  stage_data;

  logic      advance;
  logic      fire;
  result_t   result;
  result_t   result_next;
  rtc_ctrl_t rtc_ctrl;
  logic [2:0] rtc_sel;
  logic [7:0] rtc_byte;

  assign advance    = !result_valid || result_ready;
  assign fire       = stage_valid && advance;
  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_addr_bits <= ROM_ADDR_BITS_RESET;
      ram_addr_bits <= RAM_ADDR_BITS_RESET;
      has_rtc       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROM_ADDR_BITS: rom_addr_bits <= cfg_data;
        CFG_RAM_ADDR_BITS: ram_addr_bits <= cfg_data[3:0];
        CFG_HAS_RTC:       has_rtc       <= cfg_data[0];
        default:           has_rtc       <= has_rtc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage_req  <= req_type;
      stage_addr <= addr;
      stage_data <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  cbm_map u_map (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .req_type      (stage_req),
    .addr          (stage_addr),
    .data          (stage_data),
    .rom_addr_bits (rom_addr_bits),
    .ram_addr_bits (ram_addr_bits),
    .has_rtc       (has_rtc),
    .rtc_byte      (rtc_byte),
    .rtc_sel       (rtc_sel),
    .rtc_ctrl      (rtc_ctrl),
    .result        (result_next)
  );

  cbm_rtc u_rtc (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (rtc_ctrl),
    .rd_sel  (rtc_sel),
    .rd_byte (rtc_byte)
  );

  assign access_kind = result.kind;
  assign mem_addr    = result.mem_addr;
  assign write_data  = result.write_data;
  assign read_data   = result.read_data;

endmodule

`default_nettype wire

// ===== tb/sv/cbm_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the cartridge bank mapper: mirrors the mapper and clock registers,
// predicts the result of every accepted request item and compares results in order.
// Depends on cbm_pkg for request, access-kind and configuration codes.
module cbm_checker
  import cbm_pkg::*;
#(
  parameter logic [7:0] RTC_SEL_BASE = 8'h08,
  parameter logic [7:0] LATCH_FIRE   = 8'h01
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic [2:0]  req_type,
  input  logic [15:0] addr,
  input  logic [7:0]  data,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [2:0]  access_kind,
  input  logic [20:0] mem_addr,
  input  logic [7:0]  write_data,
  input  logic [7:0]  read_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output int          fail_count,
  output int          items_taken,
  output int          results_taken
);

  localparam logic [15:0] ENABLE_LIMIT = 16'h2000;
  localparam logic [15:0] BANK_LIMIT   = 16'h4000;
  localparam logic [15:0] SELECT_LIMIT = 16'h6000;
  localparam int RtcRegs    = 5;
  localparam int HaltBit    = 6;
  localparam int CarryBit   = 7;
  localparam int DayHighBit = 0;
  localparam int DaySpan    = 512;
  localparam int SecsPerDay = 86400;

  typedef enum logic [2:0] {
    RtcSeconds, RtcMinutes, RtcHours, RtcDays, RtcFlags
  } rtc_reg_t;

  // Shadow configuration.
  logic [4:0] rom_bits;
  logic [3:0] ram_bits;
  logic       rtc_present;

  // Shadow mapper and clock state.
  logic [7:0] en_reg, rom_bank, ram_bank, latch_ctrl;
  logic [7:0] secs, mins, hours, day_low, flags;
  logic [7:0] latched [RtcRegs];

  result_t expected_access [$];
  int n_items, n_results, errors;

  task automatic report(input string line);
    $display("%s", line);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [20:0] got,
                               input logic [20:0] want);
    if (got !== want)
      report($sformatf("MISMATCH result %0d: %s is 0x%0h, expected 0x%0h",
                       n_results, name, got, want));
  endtask

  // Carries the live counters forward by the given seconds; out-of-range counters
  // are folded back into their span and the unused flag bits are cleared.
  task automatic roll_clock(input int unsigned add);
    int unsigned days, total, day_count;
    days = {23'd0, flags[DayHighBit], day_low};
    total = (32'(secs) % 60) + (32'(mins) % 60) * 60 + (32'(hours) % 24) * 3600
          + days * SecsPerDay + add;
    day_count = total / SecsPerDay;
    secs = 8'(total % 60);
    mins = 8'((total / 60) % 60);
    hours = 8'((total / 3600) % 24);
    day_low = day_count[7:0];
    flags = flags & FLAGS_KEEP;
    if (day_count[8]) flags[DayHighBit] = 1'b1;
    if (day_count >= DaySpan) flags[CarryBit] = 1'b1;
  endtask

  function automatic logic [20:0] ram_location(input logic [15:0] a);
    logic [31:0] full;
    full = ({19'd0, a[12:0]} | (32'(ram_bank[1:0]) << 13)) & ((32'd1 << ram_bits) - 1);
    return full[20:0];
  endfunction

  task automatic map_request(input logic [2:0] req, input logic [15:0] a,
                             input logic [7:0] d, output result_t r);
    logic [6:0]  bank;
    int unsigned bits;
    logic [31:0] full;
    logic        enabled, clock_sel;
    rtc_reg_t    sel;
    r = '0;
    enabled = en_reg[3:0] == RAM_ENABLE_CODE[3:0];
    clock_sel = ram_bank >= RTC_SEL_BASE && ram_bank < RTC_SEL_BASE + 8'(RtcRegs);
    sel = rtc_reg_t'(3'(ram_bank - RTC_SEL_BASE));
    case (req)
      REQ_REG_WRITE: begin
        if (a < ENABLE_LIMIT) begin
          en_reg = d;
        end else if (a < BANK_LIMIT) begin
          rom_bank = d;
        end else if (a < SELECT_LIMIT) begin
          ram_bank = d;
        end else if (rtc_present) begin
          // Only a fire byte following a zero byte takes a new snapshot.
          if (latch_ctrl == 8'h00 && d == LATCH_FIRE) begin
            if (!flags[HaltBit]) roll_clock(0);
            latched[RtcSeconds] = {2'b00, secs[5:0]};
            latched[RtcMinutes] = {2'b00, mins[5:0]};
            latched[RtcHours]   = {3'b000, hours[4:0]};
            latched[RtcDays]    = day_low;
            latched[RtcFlags]   = flags & FLAGS_LATCH;
          end
          latch_ctrl = d;
        end
      end
      REQ_ROM_READ: begin
        bank = rom_bank[6:0];
        if (bank == 7'd0) bank = 7'd1;
        bits = (rom_bits > MaxRomAddrWidth) ? MaxRomAddrWidth : rom_bits;
        full = ({18'd0, a[13:0]} | (32'(bank) << 14)) & ((32'd1 << bits) - 1);
        r.kind = KIND_ROM_READ;
        r.mem_addr = full[20:0];
      end
      REQ_RAM_READ: begin
        r.kind = KIND_DATA;
        if (!enabled) begin
          r.read_data = 8'hFF;
        end else if (clock_sel) begin
          r.read_data = latched[sel];
        end else begin
          r.kind = KIND_RAM_READ;
          r.mem_addr = ram_location(a);
        end
      end
      REQ_RAM_WRITE: begin
        if (enabled && clock_sel) begin
          case (sel)
            RtcSeconds: secs = d;
            RtcMinutes: mins = d;
            RtcHours:   hours = d;
            RtcDays:    day_low = d;
            default:    flags = d;
          endcase
        end else if (enabled) begin
          r.kind = KIND_RAM_WRITE;
          r.mem_addr = ram_location(a);
          r.write_data = d;
        end
      end
      REQ_TICK: begin
        if (!flags[HaltBit]) roll_clock(1);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      rom_bits = ROM_ADDR_BITS_RESET;
      ram_bits = RAM_ADDR_BITS_RESET;
      rtc_present = 1'b1;
      en_reg = '0; rom_bank = '0; ram_bank = '0; latch_ctrl = '0;
      secs = '0; mins = '0; hours = '0; day_low = '0; flags = '0;
      for (int i = 0; i < RtcRegs; i++) latched[i] = '0;
      expected_access.delete();
      n_items = 0;
      n_results = 0;
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROM_ADDR_BITS: rom_bits = cfg_data;
          CFG_RAM_ADDR_BITS: ram_bits = cfg_data[3:0];
          CFG_HAS_RTC:       rtc_present = cfg_data[0];
          default: ;
        endcase
      end
      // Results first: a result can never belong to an item taken at the same edge.
      if (result_valid && result_ready) begin
        if (expected_access.size() == 0) begin
          report($sformatf("MISMATCH result %0d arrived with no request outstanding",
                           n_results));
        end else begin
          want = expected_access.pop_front();
          compare_field("access_kind", 21'(access_kind), 21'(want.kind));
          compare_field("mem_addr", mem_addr, want.mem_addr);
          compare_field("write_data", 21'(write_data), 21'(want.write_data));
          compare_field("read_data", 21'(read_data), 21'(want.read_data));
        end
        n_results++;
      end
      if (item_valid && item_ready) begin
        map_request(req_type, addr, data, want);
        expected_access.push_back(want);
        n_items++;
      end
    end
    items_taken <= n_items;
    results_taken <= n_results;
    fail_count <= errors;
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for cartridge_bank_mapper_with_rtc: clock, reset, configuration
// phases, request traffic, result back-pressure and the verdict.
// Depends on cbm_pkg, cbm_checker and the mapper RTL.
module tb;
  import cbm_pkg::*;

  localparam logic [7:0] SelSeconds = 8'h08;
  localparam logic [7:0] SelMinutes = 8'h09;
  localparam logic [7:0] SelHours   = 8'h0A;
  localparam logic [7:0] SelDays    = 8'h0B;
  localparam logic [7:0] SelFlags   = 8'h0C;
  localparam logic [7:0] LatchArm   = 8'h00;
  localparam logic [7:0] LatchFire  = 8'h01;
  localparam logic [7:0] HaltFlag   = 8'h40;
  localparam logic [7:0] DayHighFlag = 8'h01;
  localparam logic [2:0] ReqUnused  = 3'd7;
  localparam logic [15:0] BankRegBase   = 16'h2000;
  localparam logic [15:0] SelectRegBase = 16'h4000;
  localparam logic [15:0] LatchRegBase  = 16'h6000;
  localparam int SettleCycles = 4;
  localparam int HoldCycles   = 40;
  localparam int IdleLimit    = 1000;
  localparam int PhaseItems   = 55;
  localparam int Phases       = 7;

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [2:0]  req_type = '0;
  logic [15:0] addr = '0;
  logic [7:0]  data = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [2:0]  access_kind;
  logic [20:0] mem_addr;
  logic [7:0]  write_data;
  logic [7:0]  read_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  int fail_count, items_taken, results_taken;
  int items_sent = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  bit idle_off = 1'b0;
  bit hold_request = 1'b0;

  logic [4:0] rom_plan [Phases] = '{5'd21, 5'd15, 5'd21, 5'd18, 5'd15, 5'd15, 5'd15};
  logic [3:0] ram_plan [Phases] = '{4'd15, 4'd11, 4'd11, 4'd12, 4'd13, 4'd13, 4'd13};
  logic       rtc_plan [Phases] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

  cartridge_bank_mapper_with_rtc dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .req_type(req_type), .addr(addr), .data(data),
    .result_valid(result_valid), .result_ready(result_ready),
    .access_kind(access_kind), .mem_addr(mem_addr),
    .write_data(write_data), .read_data(read_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cbm_checker #(.RTC_SEL_BASE(SelSeconds), .LATCH_FIRE(LatchFire)) chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .req_type(req_type), .addr(addr), .data(data),
    .result_valid(result_valid), .result_ready(result_ready),
    .access_kind(access_kind), .mem_addr(mem_addr),
    .write_data(write_data), .read_data(read_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .items_taken(items_taken), .results_taken(results_taken)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when the sender asks.
  initial begin : drain
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        stall = HoldCycles;
        hold_request = 1'b0;
      end else begin
        stall = idle_off ? 0 : int'($urandom_range(0, 7));
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  task automatic send(input logic [2:0] req, input logic [15:0] a, input logic [7:0] d);
    int gap;
    gap = idle_off ? 0 : int'($urandom_range(0, 7));
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    req_type <= req;
    addr <= a;
    data <= d;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  // Stops offering items and waits for every outstanding result plus a margin.
  task automatic drain_wait();
    item_valid <= 1'b0;
    @(posedge clk);
    while (items_taken != results_taken) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_config(input logic [4:0] rom_bits, input logic [3:0] ram_bits,
                            input logic rtc);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ROM_ADDR_BITS;
    cfg_data <= rom_bits;
    @(posedge clk);
    cfg_index <= CFG_RAM_ADDR_BITS;
    cfg_data <= {1'b0, ram_bits};
    @(posedge clk);
    cfg_index <= CFG_HAS_RTC;
    cfg_data <= {4'b0000, rtc};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_addr(input logic [15:0] lo, input logic [15:0] hi);
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic logic [7:0] pick_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] enable_byte();
    if ($urandom_range(0, 3) != 0) return {4'($urandom), RAM_ENABLE_CODE[3:0]};
    return pick_byte();
  endfunction

  task automatic enable_ram();
    send(REQ_REG_WRITE, pick_addr(16'h0000, BankRegBase - 1), enable_byte());
  endtask

  task automatic select_bank(input logic [7:0] b);
    send(REQ_REG_WRITE, pick_addr(SelectRegBase, LatchRegBase - 1), b);
  endtask

  task automatic store_clock(input logic [7:0] sel, input logic [7:0] v);
    select_bank(sel);
    send(REQ_RAM_WRITE, pick_addr(16'h0000, 16'hFFFF), v);
  endtask

  task automatic run_traffic(input int n_items);
    int start;
    logic [7:0] sel;
    start = items_sent;
    while (items_sent - start < n_items) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          enable_ram();
          select_bank($urandom_range(0, 2) != 0 ? 8'($urandom_range(0, 3)) : pick_byte());
          repeat ($urandom_range(2, 6))
            send($urandom_range(0, 1) ? REQ_RAM_READ : REQ_RAM_WRITE,
                 pick_addr(16'h0000, 16'hFFFF), pick_byte());
        end
        2: begin
          send(REQ_REG_WRITE, pick_addr(BankRegBase, SelectRegBase - 1), pick_byte());
          repeat ($urandom_range(2, 5))
            send(REQ_ROM_READ, pick_addr(16'h0000, 16'hFFFF), pick_byte());
        end
        3, 4: begin
          enable_ram();
          sel = SelSeconds + 8'($urandom_range(0, 4));
          store_clock(sel, $urandom_range(0, 1) ? 8'($urandom_range(0, 23)) : pick_byte());
          repeat ($urandom_range(0, 3))
            send(REQ_TICK, pick_addr(16'h0000, 16'hFFFF), pick_byte());
        end
        5: begin
          enable_ram();
          send(REQ_REG_WRITE, pick_addr(LatchRegBase, 16'hFFFF),
               $urandom_range(0, 3) != 0 ? LatchArm : pick_byte());
          send(REQ_REG_WRITE, pick_addr(LatchRegBase, 16'hFFFF),
               $urandom_range(0, 3) != 0 ? LatchFire : pick_byte());
          repeat ($urandom_range(1, 3)) begin
            select_bank(SelSeconds + 8'($urandom_range(0, 4)));
            send(REQ_RAM_READ, pick_addr(16'h0000, 16'hFFFF), pick_byte());
          end
        end
        6: begin
          repeat ($urandom_range(1, 8))
            send(REQ_TICK, pick_addr(16'h0000, 16'hFFFF), pick_byte());
        end
        7: begin
          // Halt the clock, tick it, then let it run again.
          enable_ram();
          store_clock(SelFlags, HaltFlag | (pick_byte() & ~HaltFlag));
          repeat ($urandom_range(1, 3))
            send(REQ_TICK, pick_addr(16'h0000, 16'hFFFF), pick_byte());
          store_clock(SelFlags, pick_byte() & ~HaltFlag);
        end
        8: begin
          // Park the clock just short of the day counter wrapping, then tick it towards the wrap.
          enable_ram();
          store_clock(SelFlags, DayHighFlag);
          store_clock(SelDays, 8'hFF);
          store_clock(SelHours, 8'd23);
          store_clock(SelMinutes, 8'd59);
          store_clock(SelSeconds, 8'($urandom_range(55, 59)));
          repeat ($urandom_range(1, 6))
            send(REQ_TICK, pick_addr(16'h0000, 16'hFFFF), pick_byte());
        end
        default: begin
          repeat ($urandom_range(1, 4))
            send(3'($urandom_range(0, 7)), pick_addr(16'h0000, 16'hFFFF), pick_byte());
        end
      endcase
    end
  endtask

  initial begin : stimulus
    logic [4:0] rom_sel;
    logic [3:0] ram_sel;
    logic       rtc_sel;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_config(ROM_ADDR_BITS_RESET, RAM_ADDR_BITS_RESET, 1'b1);

    // Bank register zero maps to bank one; RAM starts out disabled.
    send(REQ_ROM_READ, 16'h4000, 8'h00);
    send(REQ_RAM_READ, 16'hA000, 8'h00);
    send(REQ_RAM_WRITE, 16'hBFFF, 8'hFF);
    send(REQ_REG_WRITE, 16'h0000, RAM_ENABLE_CODE);
    send(REQ_REG_WRITE, BankRegBase, 8'hFF);
    send(REQ_ROM_READ, 16'hFFFF, 8'hFF);
    send(REQ_REG_WRITE, SelectRegBase, 8'h03);
    send(REQ_RAM_WRITE, 16'hFFFF, 8'hFF);
    send(REQ_RAM_READ, 16'h0000, 8'h00);
    // Last second of the last day, then one tick wraps days and sets carry.
    store_clock(SelFlags, DayHighFlag);
    store_clock(SelDays, 8'hFF);
    store_clock(SelHours, 8'd23);
    store_clock(SelMinutes, 8'd59);
    store_clock(SelSeconds, 8'd59);
    send(REQ_TICK, 16'hFFFF, 8'hFF);
    send(REQ_REG_WRITE, LatchRegBase, LatchArm);
    send(REQ_REG_WRITE, 16'hFFFF, LatchFire);
    send(REQ_RAM_READ, 16'hA000, 8'h00);
    select_bank(SelFlags);
    send(REQ_RAM_READ, 16'hA000, 8'h00);
    send(ReqUnused, 16'hFFFF, 8'hFF);
    drain_wait();

    for (int p = 0; p < Phases; p++) begin
      rom_sel = rom_plan[p];
      ram_sel = ram_plan[p];
      rtc_sel = rtc_plan[p];
      if (p == 4 || p == 5) begin
        rom_sel = 5'($urandom_range(15, 21));
        ram_sel = 4'($urandom_range(11, 15));
        rtc_sel = 1'($urandom_range(0, 1));
      end
      set_config(rom_sel, ram_sel, rtc_sel);
      if (p == 1) begin
        // Back-to-back items against a long result stall fill the block.
        hold_request = 1'b1;
        idle_off = 1'b1;
        repeat (12) send(REQ_ROM_READ, pick_addr(16'h0000, 16'hFFFF), pick_byte());
        idle_off = 1'b0;
        drain_wait();
      end
      if (p == 2) idle_off = 1'b1;
      run_traffic(PhaseItems);
      idle_off = 1'b0;
      drain_wait();
    end

    $display("Ran %0d request items and checked %0d results over %0d register settings.",
             items_taken, results_taken, settings_used);
    if (fail_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cbm_pkg.sv
sv/cbm_rtc.sv
sv/cbm_map.sv
sv/cartridge_bank_mapper_with_rtc.sv
tb/sv/cbm_checker.sv
tb/sv/tb.sv
